>>> hdl/mpa_pkg.sv
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared types and constants for the modular product accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mpa_pkg;

  localparam int unsigned VAL_W     = 30;               // operand / residue width
  localparam int unsigned MOD_W     = VAL_W + 1;        // effective modulus, up to 2^30
  localparam int unsigned PROD_W    = 2 * VAL_W;        // full product width
  localparam int unsigned DIG_W     = 4;                // product bits folded per cycle
  localparam int unsigned RED_STEPS = PROD_W / DIG_W;   // reduction steps
  localparam int unsigned CNT_W     = $clog2(RED_STEPS);
  localparam int unsigned EXP_IN_W  = 16;               // exponent field width

  localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(1000000000);
  localparam logic [MOD_W-1:0] MOD_WRAP  = MOD_W'(1) << VAL_W;
  localparam logic [VAL_W-1:0] VAL_ONE   = VAL_W'(1);

  typedef enum logic [1:0] {
    OP_POW,   // partial power times base
    OP_SQR,   // base squared
    OP_ACC    // running product times power
  } mpa_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } mpa_state_e;

  typedef struct packed {
    logic done;      // result valid this cycle
    logic wrapped;   // product was at least the modulus
  } mpa_mm_status_t;

endpackage

`default_nettype wire

>>> hdl/modexp_product_accumulator.sv
// ----------------------------------------------------------------------------
// modexp_product_accumulator
// Square-and-multiply power of a base, accumulated into a running product
// modulo a configurable modulus, with a sticky wrap flag.
// ----------------------------------------------------------------------------
//  channel | signals                                             | direction
//  --------+-----------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, base_i, exponent_*_i, last_i | sink
//  out     | out_valid_o, out_stall_i, product_o, reached_modulus_o | source
//  cfg     | cfg_we_i, cfg_wdata_i (modulus)                     | sink
//
//  One item runs M square/multiply steps (at most 2*EXP_BITS - 1), then a
//  final multiply into the running product; each modular multiply goes
//  through the multiplier, then the 4-bit-per-cycle remainder in mpa_mulmod.
//  A last item also loads the output register from the S_EMIT state.
//  Reset: modulus 1e9, running product 1, flag clear; no clearing pass.
//  Input is stalled while an item is in work; a held result stalls the
//  next last item's hand-off, and input stays stalled until it is handed off.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_product_accumulator import mpa_pkg::*; #(
  parameter int unsigned EXP_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [VAL_W-1:0]    cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [VAL_W-1:0]    base_i,
  input  wire logic [EXP_IN_W-1:0] exponent_first_i,
  input  wire logic [EXP_IN_W-1:0] exponent_second_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [VAL_W-1:0]    product_o,
  output logic                     reached_modulus_o
);

  localparam logic [EXP_BITS-1:0] EXP_ONE = EXP_BITS'(1);

  mpa_state_e          state_q, state_d;
  mpa_op_e             op_q, op_sel;
  logic [VAL_W-1:0]    mod_q;
  logic [MOD_W-1:0]    mod_eff;
  logic [VAL_W-1:0]    base_q, pw_q, rp_q;
  logic [EXP_BITS-1:0] exp_q, exp_sat;
  logic [EXP_IN_W-1:0] exp_min;
  logic                last_q, wrap_q;
  logic                out_valid_q, out_flag_q;
  logic [VAL_W-1:0]    out_prod_q;
  logic                in_acc, mm_start, out_free;
  logic [VAL_W-1:0]    op_a, op_b, mm_result;
  mpa_mm_status_t      mm_status;

  assign exp_min = (exponent_first_i < exponent_second_i) ? exponent_first_i
                                                          : exponent_second_i;
  generate
    if (EXP_BITS >= EXP_IN_W) begin : g_exp_wide
      assign exp_sat = EXP_BITS'(exp_min);
    end else begin : g_exp_sat
      assign exp_sat = (|exp_min[EXP_IN_W-1:EXP_BITS]) ? '1 : exp_min[EXP_BITS-1:0];
    end
  endgenerate

  assign mod_eff  = (mod_q == '0) ? MOD_WRAP : {1'b0, mod_q};
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // odd exponent multiplies, even squares, zero folds into the product
  always_comb begin
    if (exp_q == '0) begin
      op_sel = OP_ACC;
    end else if (exp_q[0]) begin
      op_sel = OP_POW;
    end else begin
      op_sel = OP_SQR;
    end
  end

  always_comb begin
    case (op_sel)
      OP_POW: begin
        op_a = pw_q;
        op_b = base_q;
      end
      OP_SQR: begin
        op_a = base_q;
        op_b = base_q;
      end
      default: begin
        op_a = rp_q;
        op_b = pw_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ISSUE;
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: begin
        if (mm_status.done) begin
          if (op_q != OP_ACC) begin
            state_d = S_ISSUE;
          end else if (last_q) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    mm_start   = 1'b0;
    case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_ISSUE: mm_start   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mod_q   <= MOD_RESET;
      rp_q    <= VAL_ONE;
      wrap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
      if (state_q == S_WAIT && mm_status.done) begin
        wrap_q <= wrap_q | mm_status.wrapped;
        if (op_q == OP_ACC) begin
          rp_q <= mm_result;
        end
      end else if (state_q == S_EMIT && out_free) begin
        rp_q   <= VAL_ONE;
        wrap_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_q <= base_i;
      exp_q  <= exp_sat;
      last_q <= last_i;
      pw_q   <= VAL_ONE;
    end else if (state_q == S_ISSUE) begin
      op_q <= op_sel;
    end else if (state_q == S_WAIT && mm_status.done) begin
      case (op_q)
        OP_POW: begin
          pw_q  <= mm_result;
          exp_q <= exp_q - EXP_ONE;
        end
        OP_SQR: begin
          base_q <= mm_result;
          exp_q  <= exp_q >> 1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_prod_q <= rp_q;
      out_flag_q <= wrap_q;
    end
  end

  mpa_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .mod_i    (mod_eff),
    .status_o (mm_status),
    .result_o (mm_result)
  );

  assign out_valid_o       = out_valid_q;
  assign product_o         = out_prod_q;
  assign reached_modulus_o = out_flag_q;

endmodule

`default_nettype wire

>>> hdl/mpa_mulmod.sv
// ----------------------------------------------------------------------------
// mpa_mulmod
// Shared multiply-reduce unit: one 30x30 multiply, then a restoring
// remainder over the 60-bit product, DIG_W bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpa_mulmod import mpa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [VAL_W-1:0]     op_a_i,
  input  wire logic [VAL_W-1:0]     op_b_i,
  input  wire logic [MOD_W-1:0]     mod_i,
  output mpa_mm_status_t            status_o,
  output logic      [VAL_W-1:0]     result_o
);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] prod_q;
  logic [MOD_W-1:0]  mod_q;
  logic [MOD_W-1:0]  rem_q, rem_d;
  logic              sub_q, sub_d;
  logic              last_step;

  // Fold the next DIG_W product bits into the remainder.
  // rem stays below mod <= 2^30, so the shifted value fits MOD_W bits.
  always_comb begin
    logic [MOD_W-1:0] r;
    logic             s;
    r = rem_q;
    s = 1'b0;
    for (int k = 0; k < DIG_W; k++) begin
      r = {r[MOD_W-2:0], prod_q[PROD_W-1-k]};
      if (r >= mod_q) begin
        r = r - mod_q;
        s = 1'b1;
      end
    end
    rem_d = r;
    sub_d = sub_q | s;
  end

  assign last_step = busy_q && (cnt_q == CNT_W'(RED_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (last_step) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
      mod_q  <= mod_i;
      rem_q  <= '0;
      sub_q  <= 1'b0;
    end else if (busy_q) begin
      prod_q <= prod_q << DIG_W;
      rem_q  <= rem_d;
      sub_q  <= sub_d;
    end
  end

  // Any subtraction means a nonzero quotient, i.e. product >= modulus.
  assign status_o.done    = last_step;
  assign status_o.wrapped = sub_d;
  assign result_o         = rem_d[VAL_W-1:0];

endmodule

`default_nettype wire
